@@ hdl/sas_pkg.sv @@
package sas_pkg;

    // Fixed field widths of the channels
    localparam int OP_W         = 2;
    localparam int IDX_W        = 7;
    localparam int DUR_IN_W     = 16;
    localparam int STEP_OUT_W   = 6;
    localparam int STEP_TIME_W  = 16;
    localparam int TIME_W       = 24;
    localparam int LOOP_START_W = 6;
    localparam int STEP_COUNT_W = 7;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 8;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_PAUSE = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_ENABLE  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_START   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_COUNT   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GLOBAL_PAUSE = 4'd3;

    // Step table read address source
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_NEXT,
        RD_CUR
    } rd_sel_t;

    typedef struct packed {
        logic    latch;
        logic    mem_write;
        logic    sum_init;
        logic    sum_step;
        logic    tick_apply;
        logic    final_apply;
        logic    load_out;
        rd_sel_t rd_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic tick_go;
        logic wrap_sum;
        logic sum_done;
    } dp_status_t;

    typedef struct packed {
        op_t                 operation;
        logic [IDX_W-1:0]    step_index;
        logic [DUR_IN_W-1:0] duration;
        logic                infinite;
        logic                pause_value;
    } item_t;

    typedef struct packed {
        logic [STEP_OUT_W-1:0]  current_step;
        logic [STEP_TIME_W-1:0] step_time;
        logic [TIME_W-1:0]      overall_time;
        logic [TIME_W-1:0]      remaining_time;
        logic                   new_step;
        logic                   wrapped;
        logic                   ended;
        logic                   error;
    } result_t;

endpackage

@@ hdl/sas_req_if.sv @@
interface sas_req_if import sas_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [IDX_W-1:0]    step_index;
    logic [DUR_IN_W-1:0] duration;
    logic                infinite;
    logic                pause_value;

    modport source (output valid, output operation, output step_index, output duration,
                    output infinite, output pause_value, input ready);
    modport sink   (input valid, input operation, input step_index, input duration,
                    input infinite, input pause_value, output ready);
endinterface

@@ hdl/sas_rsp_if.sv @@
interface sas_rsp_if import sas_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STEP_OUT_W-1:0]  current_step;
    logic [STEP_TIME_W-1:0] step_time;
    logic [TIME_W-1:0]      overall_time;
    logic [TIME_W-1:0]      remaining_time;
    logic                   new_step;
    logic                   wrapped;
    logic                   ended;
    logic                   error;

    modport source (output valid, output current_step, output step_time, output overall_time,
                    output remaining_time, output new_step, output wrapped, output ended,
                    output error, input ready);
    modport sink   (input valid, input current_step, input step_time, input overall_time,
                    input remaining_time, input new_step, input wrapped, input ended,
                    input error, output ready);
endinterface

@@ hdl/sas_cfg_if.sv @@
interface sas_cfg_if import sas_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/sas_datapath.sv @@
module sas_datapath import sas_pkg::*; #(
    parameter int MAX_STEPS     = 64,
    parameter int DURATION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  item_t                  item,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output result_t                result
);

    localparam int PTR_W = $clog2(MAX_STEPS);
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int SCW   = (CNT_W > STEP_COUNT_W) ? CNT_W : STEP_COUNT_W;
    localparam int IXW   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int LSW   = (CNT_W > LOOP_START_W) ? CNT_W : LOOP_START_W;
    localparam int SUM_W = ((TIME_W > DURATION_BITS) ? TIME_W : DURATION_BITS) + 1;

    typedef struct packed {
        logic                     inf;
        logic [DURATION_BITS-1:0] dur;
    } entry_t;

    // Step table
    entry_t             mem [MAX_STEPS];
    entry_t             rd_reg;
    logic [PTR_W-1:0]   rd_addr;

    // Configuration registers
    logic                    loop_en_reg;
    logic [LOOP_START_W-1:0] loop_start_reg;
    logic [STEP_COUNT_W-1:0] step_count_reg;
    logic                    gpause_reg;

    // Latched item
    op_t                      op_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [DURATION_BITS-1:0] dur_reg;
    logic                     inf_reg;

    // Sequencer state
    logic [TIME_W-1:0]        total_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic [DURATION_BITS-1:0] ticks_reg;
    logic [TIME_W-1:0]        overall_reg;
    logic                     paused_reg;
    logic                     running_reg;
    logic                     nstep_reg;
    logic                     wrap_reg;
    logic                     end_reg;
    logic                     err_reg;

    // Prefix sum pass
    logic [CNT_W-1:0]  ccnt_reg;
    logic [TIME_W-1:0] acc_reg;
    logic [TIME_W-1:0] tot_s_reg;
    logic [TIME_W-1:0] ovr_s_reg;
    logic [TIME_W-1:0] lp_s_reg;

    result_t result_reg;

    logic [SCW-1:0]           sc_ext;
    logic [CNT_W-1:0]         n_steps;
    logic [IXW-1:0]           idx_ext;
    logic [CNT_W-1:0]         idx_c;
    logic                     idx_past;
    logic [LSW-1:0]           ls_ext;
    logic [PTR_W-1:0]         tgt;
    logic [PTR_W-1:0]         last_ptr;
    logic [CNT_W-1:0]         ptr_ext;
    logic [PTR_W-1:0]         cur_ptr;
    logic [CNT_W-1:0]         ptr_inc;
    logic                     at_end;
    logic [DURATION_BITS-1:0] ticks_new;
    logic [TIME_W-1:0]        overall_new;
    logic                     advance;
    logic [CNT_W-1:0]         sum_len;
    logic                     sum_done;
    logic [SUM_W-1:0]         addend;
    logic [SUM_W-1:0]         sum_wide;
    logic [TIME_W-1:0]        acc_add;
    logic [TIME_W-1:0]        remaining;

    // Steps in use, clamped to 1..MAX_STEPS
    assign sc_ext = SCW'(step_count_reg);
    always_comb
    begin
        if (sc_ext == '0)
            n_steps = CNT_W'(1);
        else if (sc_ext > SCW'(MAX_STEPS))
            n_steps = CNT_W'(MAX_STEPS);
        else
            n_steps = CNT_W'(sc_ext);
    end

    assign last_ptr = PTR_W'(n_steps - CNT_W'(1));

    // Start index, limited to the table for the prefix sum
    assign idx_ext  = IXW'(idx_reg);
    assign idx_c    = (idx_ext > IXW'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : CNT_W'(idx_ext);
    assign idx_past = (idx_ext >= IXW'(n_steps));

    // Wrap target: loop start, or the last step in use
    assign ls_ext = LSW'(loop_start_reg);
    assign tgt    = (ls_ext >= LSW'(n_steps)) ? last_ptr : PTR_W'(ls_ext);

    // Current step and its successor
    assign ptr_ext = CNT_W'(ptr_reg);
    assign cur_ptr = (ptr_ext >= n_steps) ? last_ptr : ptr_reg;
    assign ptr_inc = ptr_ext + CNT_W'(1);
    assign at_end  = (ptr_inc >= n_steps);

    // Tick update, saturating counters
    always_comb
    begin
        ticks_new   = ticks_reg;
        overall_new = overall_reg;
        if (!gpause_reg)
        begin
            if (ticks_reg != '1)
                ticks_new = ticks_reg + DURATION_BITS'(1);
            if (overall_reg != TIME_MAX)
                overall_new = overall_reg + TIME_W'(1);
        end
    end

    assign advance = !rd_reg.inf && (ticks_new >= rd_reg.dur);

    // Prefix sum pass length and saturating accumulate
    assign sum_len  = (op_reg == OP_START && idx_c > n_steps) ? idx_c : n_steps;
    assign sum_done = (ccnt_reg == sum_len);
    assign addend   = rd_reg.inf ? '0 : SUM_W'(rd_reg.dur);
    assign sum_wide = SUM_W'(acc_reg) + addend;
    assign acc_add  = (sum_wide > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_W'(sum_wide);

    assign remaining = (total_reg > overall_reg) ? (total_reg - overall_reg - TIME_W'(1)) : '0;

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_NEXT:
            begin
                if (ccnt_reg < CNT_W'(MAX_STEPS - 1))
                    rd_addr = PTR_W'(ccnt_reg + CNT_W'(1));
                else
                    rd_addr = '0;
            end
            RD_CUR:  rd_addr = cur_ptr;
            default: rd_addr = '0;
        endcase
    end

    assign status.tick_go  = running_reg && !paused_reg;
    assign status.wrap_sum = advance && at_end && loop_en_reg;
    assign status.sum_done = sum_done;

    // Step table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write && (idx_ext < IXW'(MAX_STEPS)))
            mem[PTR_W'(idx_reg)] <= '{inf: inf_reg, dur: dur_reg};
        rd_reg <= mem[rd_addr];
    end

    // Item latch, prefix sums and result register
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= item.operation;
            idx_reg <= item.step_index;
            dur_reg <= DURATION_BITS'(item.duration);
            inf_reg <= item.infinite;
        end
        if (cmd.sum_init)
        begin
            ccnt_reg <= '0;
            acc_reg  <= '0;
        end
        if (cmd.sum_step)
        begin
            if (ccnt_reg == n_steps)
                tot_s_reg <= acc_reg;
            if (ccnt_reg == idx_c)
                ovr_s_reg <= acc_reg;
            if (ccnt_reg == CNT_W'(tgt))
                lp_s_reg <= acc_reg;
            if (!sum_done)
            begin
                acc_reg  <= acc_add;
                ccnt_reg <= ccnt_reg + CNT_W'(1);
            end
        end
        if (cmd.load_out)
        begin
            result_reg.current_step   <= STEP_OUT_W'(ptr_reg);
            result_reg.step_time      <= STEP_TIME_W'(ticks_reg);
            result_reg.overall_time   <= overall_reg;
            result_reg.remaining_time <= remaining;
            result_reg.new_step       <= nstep_reg;
            result_reg.wrapped        <= wrap_reg;
            result_reg.ended          <= end_reg;
            result_reg.error          <= err_reg;
        end
    end

    // Configuration and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_en_reg    <= 1'b1;
            loop_start_reg <= '0;
            step_count_reg <= STEP_COUNT_W'(1);
            gpause_reg     <= 1'b0;
            total_reg      <= '0;
            ptr_reg        <= '0;
            ticks_reg      <= '0;
            overall_reg    <= '0;
            paused_reg     <= 1'b0;
            running_reg    <= 1'b0;
            nstep_reg      <= 1'b0;
            wrap_reg       <= 1'b0;
            end_reg        <= 1'b0;
            err_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LOOP_ENABLE:  loop_en_reg    <= cfg_data[0];
                    REG_LOOP_START:   loop_start_reg <= cfg_data[LOOP_START_W-1:0];
                    REG_STEP_COUNT:   step_count_reg <= cfg_data[STEP_COUNT_W-1:0];
                    REG_GLOBAL_PAUSE: gpause_reg     <= cfg_data[0];
                    default: ;
                endcase
            end

            if (cmd.latch)
            begin
                nstep_reg <= 1'b0;
                wrap_reg  <= 1'b0;
                end_reg   <= 1'b0;
                err_reg   <= 1'b0;
                if (item.operation == OP_PAUSE)
                    paused_reg <= item.pause_value;
            end

            // Tick: count time, then move on when the step is used up
            if (cmd.tick_apply)
            begin
                overall_reg <= overall_new;
                if (advance && !at_end)
                    ticks_reg <= '0;
                else
                    ticks_reg <= ticks_new;
                if (advance)
                begin
                    if (!at_end)
                    begin
                        ptr_reg   <= PTR_W'(ptr_inc);
                        nstep_reg <= 1'b1;
                    end
                    else
                    begin
                        wrap_reg <= 1'b1;
                        if (!loop_en_reg)
                        begin
                            running_reg <= 1'b0;
                            end_reg     <= 1'b1;
                            ptr_reg     <= last_ptr;
                        end
                    end
                end
            end

            // Commit the results of a prefix sum pass
            if (cmd.final_apply)
            begin
                case (op_reg)
                    OP_LOAD: total_reg <= tot_s_reg;
                    OP_START:
                    begin
                        total_reg <= tot_s_reg;
                        if (idx_past)
                        begin
                            wrap_reg <= 1'b1;
                            if (loop_en_reg)
                            begin
                                ptr_reg     <= tgt;
                                overall_reg <= lp_s_reg;
                                ticks_reg   <= '0;
                                running_reg <= 1'b1;
                                nstep_reg   <= 1'b1;
                            end
                            else
                            begin
                                overall_reg <= ovr_s_reg;
                                running_reg <= 1'b0;
                                end_reg     <= 1'b1;
                                err_reg     <= 1'b1;
                                ptr_reg     <= last_ptr;
                            end
                        end
                        else
                        begin
                            overall_reg <= ovr_s_reg;
                            ptr_reg     <= PTR_W'(idx_reg);
                            ticks_reg   <= '0;
                            running_reg <= 1'b1;
                            nstep_reg   <= 1'b1;
                        end
                    end
                    OP_TICK:
                    begin
                        ptr_reg     <= tgt;
                        overall_reg <= lp_s_reg;
                        ticks_reg   <= '0;
                        running_reg <= 1'b1;
                        nstep_reg   <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign result = result_reg;

endmodule

@@ hdl/sas_controller.sv @@
module sas_controller import sas_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  op_t        req_op,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SUM_INIT,
        ST_SUM,
        ST_TICK_RD,
        ST_TICK,
        ST_APPLY,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;

    // Sequencing and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch = 1'b1;
                    case (req_op)
                        OP_LOAD:  state_next = ST_WRITE;
                        OP_START: state_next = ST_SUM_INIT;
                        OP_TICK:  state_next = status.tick_go ? ST_TICK_RD : ST_FINISH;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.mem_write = 1'b1;
                state_next    = ST_SUM_INIT;
            end
            ST_SUM_INIT:
            begin
                cmd.sum_init = 1'b1;
                cmd.rd_sel   = RD_ZERO;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                cmd.rd_sel   = RD_NEXT;
                if (status.sum_done)
                    state_next = ST_APPLY;
            end
            ST_TICK_RD:
            begin
                cmd.rd_sel = RD_CUR;
                state_next = ST_TICK;
            end
            ST_TICK:
            begin
                cmd.tick_apply = 1'b1;
                state_next     = status.wrap_sum ? ST_SUM_INIT : ST_FINISH;
            end
            ST_APPLY:
            begin
                cmd.final_apply = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register valid: set on load, cleared on transfer
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/sprite_animation_sequencer_unit.sv @@
// Sprite animation frame sequencer.
// req carries one item per transfer: load a step duration, start at a step,
// tick, or set the pause flag. rsp returns exactly one result per item with
// the shown step, step and overall time, remaining time and event flags.
// cfg writes loop_enable, loop_start, step_count and global_pause by index;
// it is always ready. The user must see that it is written only while the block is idle;
// the block itself does not enforce this. Items are handled one at a time;
// n is the number of steps in use. A load runs a prefix sum pass over n step
// table entries, a start one over max(n, start index capped at MAX_STEPS)
// entries; the pass reads one entry per cycle. A tick taken while not
// running or paused skips the table read. A tick that wraps to the loop
// start adds a pass over n entries.
// The result sits in an output register, so a new item is taken while the
// previous result waits; when rsp stalls, a finished result is held until
// the output register is free.
// Reset clears the sequencer state and loads the register defaults; the step
// table is not cleared and must be loaded before use.
module sprite_animation_sequencer_unit import sas_pkg::*; #(
    parameter int MAX_STEPS     = 64,
    parameter int DURATION_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sas_req_if.sink    req,
    sas_rsp_if.source  rsp,
    sas_cfg_if.sink    cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;
    item_t      item;
    result_t    result;
    logic       cfg_write;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    assign item.operation   = op_t'(req.operation);
    assign item.step_index  = req.step_index;
    assign item.duration    = req.duration;
    assign item.infinite    = req.infinite;
    assign item.pause_value = req.pause_value;

    sas_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (item.operation),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sas_datapath #(
        .MAX_STEPS     (MAX_STEPS),
        .DURATION_BITS (DURATION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .result    (result)
    );

    assign rsp.current_step   = result.current_step;
    assign rsp.step_time      = result.step_time;
    assign rsp.overall_time   = result.overall_time;
    assign rsp.remaining_time = result.remaining_time;
    assign rsp.new_step       = result.new_step;
    assign rsp.wrapped        = result.wrapped;
    assign rsp.ended          = result.ended;
    assign rsp.error          = result.error;

endmodule

@@ dv/tb.sv @@
module tb;
    import sas_pkg::*;

    localparam int STEPS_MAX      = 64;
    localparam int SEGS_PER_PHASE = 5;
    localparam int SEG_ITEMS      = 36;
    localparam int INF_TICKS      = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 20;

    // One row of the directed stimulus: either a register write or an item
    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        item_t                  it;
        bit                     typed;
        result_t                want;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sas_req_if req_bus ();
    sas_rsp_if rsp_bus ();
    sas_cfg_if cfg_bus ();

    sprite_animation_sequencer_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sequencer shadow state
    logic [15:0] frame_len [STEPS_MAX];
    bit          frame_inf [STEPS_MAX];
    logic [23:0] total_len;
    logic [5:0]  cur_step;
    logic [15:0] step_ticks;
    logic [23:0] anim_ticks;
    bit          held;
    bit          playing;
    // Register shadow, reset values
    bit          loop_on    = 1'b1;
    logic [5:0]  loop_to    = '0;
    logic [6:0]  count_reg  = 7'd1;
    bit          freeze_all = 1'b0;

    result_t due_status[$];
    dir_row_t dir_rows[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int req_idle_pct   = 0;
    int rsp_stall_pct  = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    result_t got_status;
    result_t want_status;

    function automatic int unsigned steps_live();
        int unsigned n;
        n = 32'(count_reg);
        if (n == 0) n = 1;
        if (n > STEPS_MAX) n = STEPS_MAX;
        return n;
    endfunction

    // Sum of finite durations of steps below k, saturating at 24 bits
    function automatic logic [23:0] sum_upto(int unsigned k);
        int unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i < k && i < STEPS_MAX; i++)
        begin
            if (!frame_inf[i]) acc += 32'(frame_len[i]);
            if (acc > 32'(TIME_MAX)) acc = 32'(TIME_MAX);
        end
        return acc[23:0];
    endfunction

    // Show step s, or handle running off the end of the animation
    function automatic void move_to(int unsigned s, inout result_t r);
        int unsigned n;
        int unsigned target;
        n = steps_live();
        target = s;
        if (target >= n)
        begin
            r.wrapped = 1'b1;
            if (loop_on)
            begin
                target = (32'(loop_to) >= n) ? n - 1 : 32'(loop_to);
                anim_ticks = sum_upto(target);
            end
            else
            begin
                playing = 1'b0;
                r.ended = 1'b1;
                cur_step = 6'(n - 1);
                return;
            end
        end
        cur_step = 6'(target);
        step_ticks = '0;
        playing = 1'b1;
        r.new_step = 1'b1;
    endfunction

    function automatic result_t advance_sequencer(item_t it);
        result_t r;
        int unsigned cur;
        r = '0;
        case (it.operation)
            OP_LOAD:
            begin
                if (it.step_index < STEPS_MAX)
                begin
                    frame_len[it.step_index] = it.duration;
                    frame_inf[it.step_index] = it.infinite;
                end
                total_len = sum_upto(steps_live());
            end
            OP_START:
            begin
                total_len = sum_upto(steps_live());
                anim_ticks = sum_upto(32'(it.step_index));
                move_to(32'(it.step_index), r);
                r.error = r.ended;
            end
            OP_TICK:
            begin
                if (playing && !held)
                begin
                    cur = (32'(cur_step) >= steps_live()) ? steps_live() - 1 : 32'(cur_step);
                    if (!freeze_all)
                    begin
                        if (anim_ticks != TIME_MAX) anim_ticks++;
                        if (step_ticks != '1) step_ticks++;
                    end
                    if (!frame_inf[cur] && step_ticks >= frame_len[cur])
                        move_to(32'(cur_step) + 1, r);
                end
            end
            default: held = it.pause_value;
        endcase
        r.current_step   = cur_step;
        r.step_time      = step_ticks;
        r.overall_time   = anim_ticks;
        r.remaining_time = (total_len > anim_ticks) ? total_len - anim_ticks - 24'd1 : '0;
        return r;
    endfunction

    function automatic logic [15:0] pick_duration();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return 16'($urandom_range(4));
        if (roll < 90) return 16'($urandom_range(40, 5));
        return 16'($urandom_range(65535));
    endfunction

    // Random item; fields the operation does not use stay random
    function automatic item_t random_item(int unsigned n);
        item_t it;
        int unsigned roll;
        it.operation   = op_t'($urandom_range(3));
        it.step_index  = 7'($urandom_range(127));
        it.duration    = 16'($urandom_range(65535));
        it.infinite    = 1'($urandom_range(1));
        it.pause_value = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < 62)
            it.operation = OP_TICK;
        else if (roll < 72)
        begin
            it.operation = OP_START;
            if ($urandom_range(4) != 0) it.step_index = 7'($urandom_range(n - 1));
        end
        else if (roll < 84)
        begin
            it.operation = OP_LOAD;
            if ($urandom_range(6) != 0) it.step_index = 7'($urandom_range(n - 1));
            it.duration = pick_duration();
            it.infinite = ($urandom_range(6) == 0);
        end
        else if (roll < 92)
        begin
            it.operation   = OP_PAUSE;
            it.pause_value = ($urandom_range(9) < 3);
        end
        return it;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.it      = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic dir_row_t op_row(op_t op, int idx, int dur, bit inf, bit pv);
        dir_row_t r;
        r = cfg_row('0, '0);
        r.is_cfg         = 1'b0;
        r.it.operation   = op;
        r.it.step_index  = idx[IDX_W-1:0];
        r.it.duration    = dur[DUR_IN_W-1:0];
        r.it.infinite    = inf;
        r.it.pause_value = pv;
        return r;
    endfunction

    // flags: {new_step, wrapped, ended, error}
    function automatic dir_row_t chk_row(op_t op, int idx, int dur, bit inf, bit pv,
                                         int step, int st, int ot, int rt, logic [3:0] flags);
        dir_row_t r;
        r = op_row(op, idx, dur, inf, pv);
        r.typed                = 1'b1;
        r.want.current_step    = step[STEP_OUT_W-1:0];
        r.want.step_time       = st[STEP_TIME_W-1:0];
        r.want.overall_time    = ot[TIME_W-1:0];
        r.want.remaining_time  = rt[TIME_W-1:0];
        {r.want.new_step, r.want.wrapped, r.want.ended, r.want.error} = flags;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP) $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(string field, logic [23:0] got, logic [23:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", field, got, want));
    endtask

    // Present one item and wait for its transfer; valid stays up on return
    task automatic send_item(item_t it, bit typed = 1'b0, result_t want = '0);
        result_t predicted;
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_bus.valid = 1'b0;
            @(negedge clk);
        end
        req_bus.valid       = 1'b1;
        req_bus.operation   = it.operation;
        req_bus.step_index  = it.step_index;
        req_bus.duration    = it.duration;
        req_bus.infinite    = it.infinite;
        req_bus.pause_value = it.pause_value;
        do @(posedge clk); while (!req_bus.ready);
        predicted = advance_sequencer(it);
        due_status.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain();
        req_bus.valid = 1'b0;
        while (due_status.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            REG_LOOP_ENABLE:  loop_on    = val[0];
            REG_LOOP_START:   loop_to    = val[5:0];
            REG_STEP_COUNT:   count_reg  = val[6:0];
            REG_GLOBAL_PAUSE: freeze_all = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Full register setup; unused bits of the one-bit registers are random
    task automatic program_regs(bit le, logic [7:0] ls, logic [7:0] sc, bit gp);
        write_reg(REG_LOOP_ENABLE, {7'($urandom_range(127)), le});
        write_reg(REG_LOOP_START, ls);
        write_reg(REG_STEP_COUNT, sc);
        write_reg(REG_GLOBAL_PAUSE, {7'($urandom_range(127)), gp});
        if ($urandom_range(3) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(15, 4)), CFG_DATA_W'($urandom_range(255)));
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got_status.current_step   = rsp_bus.current_step;
            got_status.step_time      = rsp_bus.step_time;
            got_status.overall_time   = rsp_bus.overall_time;
            got_status.remaining_time = rsp_bus.remaining_time;
            got_status.new_step       = rsp_bus.new_step;
            got_status.wrapped        = rsp_bus.wrapped;
            got_status.ended          = rsp_bus.ended;
            got_status.error          = rsp_bus.error;
            if (due_status.size() == 0)
                report_mismatch("result with no item outstanding");
            else
            begin
                want_status = due_status.pop_front();
                check_field("current_step", got_status.current_step, want_status.current_step);
                check_field("step_time", got_status.step_time, want_status.step_time);
                check_field("overall_time", got_status.overall_time, want_status.overall_time);
                check_field("remaining_time", got_status.remaining_time,
                            want_status.remaining_time);
                check_field("new_step", got_status.new_step, want_status.new_step);
                check_field("wrapped", got_status.wrapped, want_status.wrapped);
                check_field("ended", got_status.ended, want_status.ended);
                check_field("error", got_status.error, want_status.error);
            end
        end
    end

    // Response ready: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_bus.ready = 1'b0;
        end
        else
            rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        item_t it;
        int unsigned n;
        int seg_no;

        req_bus.valid       = 1'b0;
        req_bus.operation   = '0;
        req_bus.step_index  = '0;
        req_bus.duration    = '0;
        req_bus.infinite    = 1'b0;
        req_bus.pause_value = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        rsp_bus.ready       = 1'b0;
        total_len  = '0;
        cur_step   = '0;
        step_ticks = '0;
        anim_ticks = '0;
        held       = 1'b0;
        playing    = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill the whole step table with one step in use, entry 0 first,
        // so no later sum ever reads an entry that was never loaded
        for (int i = 0; i < STEPS_MAX; i++)
        begin
            it = random_item(1);
            it.operation  = OP_LOAD;
            it.step_index = 7'(i);
            it.duration   = pick_duration();
            it.infinite   = ($urandom_range(9) == 0);
            send_item(it);
        end

        // Directed: three steps, the last one infinite at first
        dir_rows.push_back(op_row(OP_LOAD, 1, 3, 1'b0, 1'b0));
        dir_rows.push_back(op_row(OP_LOAD, 2, 65535, 1'b1, 1'b0));
        dir_rows.push_back(chk_row(OP_LOAD, 0, 2, 1'b0, 1'b0, 0, 0, 0, 1, 4'b0000));
        dir_rows.push_back(cfg_row(REG_STEP_COUNT, 3));
        dir_rows.push_back(cfg_row(REG_LOOP_ENABLE, 0));
        dir_rows.push_back(chk_row(OP_START, 0, 0, 1'b0, 1'b0, 0, 0, 0, 4, 4'b1000));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 0, 1, 1, 3, 4'b0000));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 1, 0, 2, 2, 4'b1000));
        // instance pause holds time
        dir_rows.push_back(chk_row(OP_PAUSE, 0, 0, 1'b0, 1'b1, 1, 0, 2, 2, 4'b0000));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 1, 0, 2, 2, 4'b0000));
        dir_rows.push_back(chk_row(OP_PAUSE, 0, 0, 1'b0, 1'b0, 1, 0, 2, 2, 4'b0000));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 1, 1, 3, 1, 4'b0000));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 1, 2, 4, 0, 4'b0000));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 2, 0, 5, 0, 4'b1000));
        // infinite step never ends; remaining time floors at zero
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 2, 1, 6, 0, 4'b0000));
        dir_rows.push_back(cfg_row(REG_GLOBAL_PAUSE, 1));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 2, 1, 6, 0, 4'b0000));
        dir_rows.push_back(cfg_row(REG_GLOBAL_PAUSE, 0));
        // start past the end without looping: ends with error
        dir_rows.push_back(chk_row(OP_START, 3, 0, 1'b0, 1'b0, 2, 1, 5, 0, 4'b0111));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 2, 1, 5, 0, 4'b0000));
        // looping with a loop start past the step count
        dir_rows.push_back(cfg_row(REG_LOOP_ENABLE, 1));
        dir_rows.push_back(cfg_row(REG_LOOP_START, 63));
        dir_rows.push_back(chk_row(OP_START, 127, 0, 1'b0, 1'b0, 2, 0, 5, 0, 4'b1100));
        dir_rows.push_back(chk_row(OP_START, 1, 0, 1'b0, 1'b0, 1, 0, 2, 2, 4'b1000));
        dir_rows.push_back(chk_row(OP_LOAD, 2, 0, 1'b0, 1'b0, 1, 0, 2, 2, 4'b0000));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 1, 1, 3, 1, 4'b0000));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 1, 2, 4, 0, 4'b0000));
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 2, 0, 5, 0, 4'b1000));
        // zero-length last step wraps on the next tick
        dir_rows.push_back(chk_row(OP_TICK, 0, 0, 1'b0, 1'b0, 2, 0, 5, 0, 4'b1100));
        // load past the table is dropped
        dir_rows.push_back(chk_row(OP_LOAD, 127, 65535, 1'b1, 1'b1, 2, 0, 5, 0, 4'b0000));
        // step count zero acts as one; shown step lies beyond it
        dir_rows.push_back(cfg_row(REG_STEP_COUNT, 0));
        dir_rows.push_back(chk_row(OP_LOAD, 0, 7, 1'b0, 1'b0, 2, 0, 5, 1, 4'b0000));
        dir_rows.push_back(op_row(OP_TICK, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(op_row(OP_TICK, 0, 0, 1'b0, 1'b0));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                drain();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
                send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random: three idling phases, each a run of config segments
        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            case (phase)
                0: begin req_idle_pct = 6;  rsp_stall_pct = 65; end
                1: begin req_idle_pct = 65; rsp_stall_pct = 6;  end
                default:
                begin
                    req_idle_pct = 0;
                    rsp_stall_pct = 0;
                    hold_request = 1'b1;
                end
            endcase
            for (int seg = 0; seg < SEGS_PER_PHASE; seg++)
            begin
                seg_no = phase * SEGS_PER_PHASE + seg;
                drain();
                case (seg_no)
                    0: program_regs(1'b1, 8'hFF, 8'hFF, 1'b0);
                    1: program_regs(1'b0, 8'd0, 8'd64, 1'b0);
                    2: program_regs(1'b1, 8'd5, 8'd0, 1'b1);
                    default:
                        program_regs(1'($urandom_range(1)),
                                     8'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                                 : $urandom_range(7)),
                                     8'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                                 : $urandom_range(8, 1)),
                                     ($urandom_range(99) < 15));
                endcase
                n = steps_live();
                // well-formed opening: load the first steps, then start
                for (int i = 0; i < n && i < 6; i++)
                begin
                    it = random_item(n);
                    it.operation  = OP_LOAD;
                    it.step_index = 7'(i);
                    it.duration   = pick_duration();
                    it.infinite   = ($urandom_range(7) == 0);
                    send_item(it);
                end
                it = random_item(n);
                it.operation  = OP_START;
                it.step_index = 7'($urandom_range(n - 1));
                send_item(it);
                repeat (SEG_ITEMS) send_item(random_item(n));
            end
        end

        // Run of ticks on an infinite step
        drain();
        program_regs(1'b1, 8'd0, 8'd1, 1'b0);
        it = random_item(1);
        it.operation  = OP_LOAD;
        it.step_index = 0;
        it.infinite   = 1'b1;
        send_item(it);
        it = random_item(1);
        it.operation  = OP_START;
        it.step_index = 0;
        send_item(it);
        it = random_item(1);
        it.operation = OP_PAUSE;
        it.pause_value = 1'b0;
        send_item(it);
        repeat (INF_TICKS)
        begin
            it = random_item(1);
            it.operation = OP_TICK;
            send_item(it);
        end

        drain();
        repeat (16) @(negedge clk);
        if (mismatch_count == 0 && due_status.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
